// ----- src/pqms_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the max-select priority queue.
// No dependencies; used by the interfaces, the cell and the top level.
package pqms_pkg;

  localparam int unsigned DEPTH   = 128;
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PRIO_W  = 32;
  localparam int unsigned OCC_W   = 8;

  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic        [DATA_W-1:0] data;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t ins;
  } cell_ctrl_t;

endpackage

// ----- src/pqms_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and result transactions.
// Depends on pqms_pkg for field widths.
interface pqms_in_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic        [pqms_pkg::DATA_W-1:0]  data_in;
  logic signed [pqms_pkg::PRIO_W-1:0]  priority_in;

  modport source (output valid, output func, output data_in, output priority_in,
                  input ready);
  modport sink   (input valid, input func, input data_in, input priority_in,
                  output ready);
endinterface

interface pqms_out_if;
  logic                                valid;
  logic                                ready;
  logic        [pqms_pkg::DATA_W-1:0]  data_out;
  logic signed [pqms_pkg::PRIO_W-1:0]  priority_out;
  logic        [1:0]                   status;
  logic        [pqms_pkg::OCC_W-1:0]   occupancy;

  modport source (output valid, output data_out, output priority_out,
                  output status, output occupancy, input ready);
  modport sink   (input valid, input data_out, input priority_out,
                  input status, input occupancy, output ready);
endinterface

// ----- src/pqms_cell.sv -----
`timescale 1ns / 1ps
// One slot of the sorted shift-register queue.
// Depends on pqms_pkg for entry_t and cell_ctrl_t.
module pqms_cell (
  input  logic                 clk_i,
  input  pqms_pkg::cell_ctrl_t ctrl_i,
  input  logic                 occupied_i,
  input  logic                 take_left_i,
  input  pqms_pkg::entry_t     left_entry_i,
  input  pqms_pkg::entry_t     right_entry_i,
  output logic                 take_o,
  output pqms_pkg::entry_t     entry_o
);

  pqms_pkg::entry_t entry_q, entry_d;

  // New entry goes ahead of this slot only on strictly greater priority,
  // so equal priorities keep arrival order.
  assign take_o  = !occupied_i || (ctrl_i.ins.prio > entry_q.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.enq) begin
      if (take_left_i) begin
        entry_d = left_entry_i;
      end else if (take_o) begin
        entry_d = ctrl_i.ins;
      end
    end else if (ctrl_i.deq) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ----- src/priority_queue_max_select.sv -----
`timescale 1ns / 1ps
// Max-select priority queue built as a sorted chain of cells.
// A result is presented from the result register in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while the result sink is ready; every cell compares and shifts in parallel.
// Reset clears the entry count and the result valid flag; cell contents stay
// undefined until written and are never read beyond the count.
module priority_queue_max_select (
  input  logic        clk_i,
  input  logic        rst_ni,
  pqms_in_if.sink     in_i,
  pqms_out_if.source  out_o
);

  localparam int unsigned CW = pqms_pkg::COUNT_W;

  logic [CW-1:0] count_q, count_d;
  logic          full, empty;
  logic          in_fire, is_enq, is_deq, enq_ok, deq_ok;

  pqms_pkg::cell_ctrl_t ctrl;
  pqms_pkg::entry_t     cell_entry [pqms_pkg::DEPTH];
  logic                 cell_take  [pqms_pkg::DEPTH];

  // Result register
  logic                               out_valid_q;
  logic        [pqms_pkg::DATA_W-1:0] data_q;
  logic signed [pqms_pkg::PRIO_W-1:0] prio_q;
  pqms_pkg::status_e                  status_q, status_d;
  logic        [pqms_pkg::OCC_W-1:0]  occ_q;

  assign full  = (count_q == CW'(pqms_pkg::DEPTH));
  assign empty = (count_q == '0);

  // Take a new transaction whenever the result register is free or draining.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign is_enq     = (pqms_pkg::func_e'(in_i.func) == pqms_pkg::FUNC_ENQ);
  assign is_deq     = (pqms_pkg::func_e'(in_i.func) == pqms_pkg::FUNC_DEQ);
  assign enq_ok     = in_fire && is_enq && !full;
  assign deq_ok     = in_fire && is_deq && !empty;

  assign ctrl.enq      = enq_ok;
  assign ctrl.deq      = deq_ok;
  assign ctrl.ins.data = in_i.data_in;
  assign ctrl.ins.prio = in_i.priority_in;

  // Chain of cells, kept sorted by priority with the oldest first among ties.
  // Cell 0 always holds the entry to serve next.
  for (genvar g = 0; g < pqms_pkg::DEPTH; g++) begin : g_cell
    logic             occupied, take_left;
    pqms_pkg::entry_t left_entry, right_entry;

    assign occupied = (CW'(g) < count_q);

    if (g == 0) begin : g_first
      assign take_left  = 1'b0;
      assign left_entry = cell_entry[g];
    end else begin : g_mid
      assign take_left  = cell_take[g-1];
      assign left_entry = cell_entry[g-1];
    end

    if (g == pqms_pkg::DEPTH - 1) begin : g_last
      assign right_entry = cell_entry[g];
    end else begin : g_inner
      assign right_entry = cell_entry[g+1];
    end

    pqms_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occupied_i    (occupied),
      .take_left_i   (take_left),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .take_o        (cell_take[g]),
      .entry_o       (cell_entry[g])
    );
  end

  // Advance the count on a successful enqueue or dequeue.
  always_comb begin
    count_d = count_q;
    if (enq_ok) begin
      count_d = count_q + CW'(1);
    end else if (deq_ok) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    status_d = pqms_pkg::STATUS_OK;
    if (is_enq && full) begin
      status_d = pqms_pkg::STATUS_FULL;
    end else if (is_deq && empty) begin
      status_d = pqms_pkg::STATUS_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the result; zero data and priority unless a dequeue succeeded.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      data_q   <= deq_ok ? cell_entry[0].data : '0;
      prio_q   <= deq_ok ? cell_entry[0].prio : '0;
      status_q <= status_d;
      occ_q    <= pqms_pkg::OCC_W'(count_d);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.data_out     = data_q;
  assign out_o.priority_out = prio_q;
  assign out_o.status       = status_q;
  assign out_o.occupancy    = occ_q;

  // Count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(pqms_pkg::DEPTH))
    else $error("entry count above capacity");

  // An accepted enqueue into a non-full queue adds exactly one entry.
  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq_ok |=> count_q == CW'($past(count_q) + CW'(1)))
    else $error("enqueue did not advance count");

  // The head of the chain never has lower priority than its neighbour.
  a_sorted_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= CW'(2) |-> cell_entry[0].prio >= cell_entry[1].prio)
    else $error("chain head out of order");

  // A dequeue on empty reports nothing removed and an empty queue.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == pqms_pkg::STATUS_EMPTY) |->
      (data_q == '0 && prio_q == '0 && occ_q == '0))
    else $error("empty dequeue result not cleared");

endmodule

// ----- bench/pqms_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the max-select priority queue: watches both channels,
// predicts every result and compares it field by field.
// Depends on pqms_pkg and the channel interfaces in pqms_if.
module pqms_checker
  import pqms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  pqms_in_if          req_i,
  pqms_out_if         rsp_i,
  output int unsigned mismatch_count_o,
  output int unsigned outstanding_o
);

  typedef struct packed {
    logic        [DATA_W-1:0] data;
    logic signed [PRIO_W-1:0] prio;
    status_e                  status;
    logic        [OCC_W-1:0]  occupancy;
  } result_t;

  entry_t      held_entries[$];    // oldest first
  result_t     awaited_results[$];
  int unsigned mismatches  = 0;
  int unsigned outstanding = 0;

  assign mismatch_count_o = mismatches;
  assign outstanding_o    = outstanding;

  // Apply one request to the shadow queue and return the result it earns.
  function automatic result_t serve_request(func_e op, logic [DATA_W-1:0] data,
                                            logic signed [PRIO_W-1:0] prio);
    result_t res;
    entry_t  fresh;
    int      best;
    res        = '0;
    res.status = STATUS_OK;
    if (op == FUNC_ENQ) begin
      if (held_entries.size() >= DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        fresh.data = data;
        fresh.prio = prio;
        held_entries.push_back(fresh);
      end
    end else if (held_entries.size() == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      // strict compare keeps the oldest among equal priorities
      best = 0;
      for (int i = 1; i < held_entries.size(); i++) begin
        if ($signed(held_entries[i].prio) > $signed(held_entries[best].prio)) best = i;
      end
      res.data = held_entries[best].data;
      res.prio = held_entries[best].prio;
      held_entries.delete(best);
    end
    res.occupancy = OCC_W'(held_entries.size());
    return res;
  endfunction

  task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("[%0t] %s mismatch: expected %h, got %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      held_entries.delete();
      awaited_results.delete();
      outstanding = 0;
    end else begin
      if (req_i.valid && req_i.ready)
        awaited_results.push_back(serve_request(func_e'(req_i.func), req_i.data_in,
                                                req_i.priority_in));
      if (rsp_i.valid && rsp_i.ready) begin
        if (awaited_results.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] unexpected result: data %h priority %h status %0d occupancy %0d",
                     $time, rsp_i.data_out, rsp_i.priority_out, rsp_i.status,
                     rsp_i.occupancy);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          report_field("data_out", want.data, rsp_i.data_out);
          report_field("priority_out", want.prio, rsp_i.priority_out);
          report_field("status", {30'd0, want.status}, {30'd0, rsp_i.status});
          report_field("occupancy", {24'd0, want.occupancy}, {24'd0, rsp_i.occupancy});
        end
      end
      outstanding = awaited_results.size();
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Top level of the max-select priority queue bench: clock, reset, request
// stimulus and result back-pressure; checking lives in pqms_checker.
// Depends on pqms_pkg, pqms_if, pqms_checker and the block itself.
module testbench;
  import pqms_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 10;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned cycle_count = 0;

  // Idling controls, switched per phase by the stimulus.
  bit          src_idling   = 1'b0;
  bit          sink_idling  = 1'b0;
  bit          hold_off_req = 1'b0;   // raised by stimulus, cleared by the sink
  int          queued       = 0;      // occupancy the stimulus expects, for shaping only

  pqms_in_if  req_ch ();
  pqms_out_if rsp_ch ();

  priority_queue_max_select dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (rsp_ch)
  );

  pqms_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req_ch),
    .rsp_i            (rsp_ch),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  // 4 ns period.
  always #2 clk_i = ~clk_i;

  // Watchdog: count cycles and give up well past the slowest correct run.
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Bias priorities towards small values so that ties are common, and mix
  // in the extremes of the signed range.
  function automatic logic signed [PRIO_W-1:0] pick_priority();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return $urandom;
    if (roll < 8) return PRIO_W'($signed($urandom_range(0, 6)) - 3);
    if (roll == 8) return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  // Sink side: hold ready low for a long stretch on request, otherwise
  // accept with random stalls when idling is switched on.
  initial begin : sink
    int unsigned stall_left;
    stall_left   = 0;
    rsp_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (sink_idling && $urandom_range(0, 3) == 0) stall_left = idle_gap();
      end
    end
  end

  // Offer one request transaction, starting at a falling edge, and return
  // at the falling edge after it has been taken. Keep valid high into the
  // next transaction unless a gap is drawn.
  task automatic offer_request(func_e op, logic [DATA_W-1:0] data,
                               logic signed [PRIO_W-1:0] prio);
    int unsigned gap;
    req_ch.valid       <= 1'b1;
    req_ch.func        <= op;
    req_ch.data_in     <= data;
    req_ch.priority_in <= prio;
    do @(posedge clk_i); while (!req_ch.ready);
    if (op == FUNC_ENQ) begin
      if (queued < DEPTH) queued++;
    end else if (queued > 0) begin
      queued--;
    end
    @(negedge clk_i);
    gap = src_idling ? idle_gap() : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic enqueue(logic [DATA_W-1:0] data, logic signed [PRIO_W-1:0] prio);
    offer_request(FUNC_ENQ, data, prio);
  endtask

  // Dequeue fields carry junk: the block must ignore them.
  task automatic dequeue();
    offer_request(FUNC_DEQ, $urandom, $urandom);
  endtask

  // Mixed traffic; enq_pct sets the share of enqueues.
  task automatic random_burst(int unsigned count, int unsigned enq_pct);
    repeat (count) begin
      if ($urandom_range(0, 99) < enq_pct) enqueue(pick_data(), pick_priority());
      else dequeue();
    end
  endtask

  // Drop valid and hold the sender until every result has come back.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    req_ch.valid       = 1'b0;
    req_ch.func        = FUNC_ENQ;
    req_ch.data_in     = '0;
    req_ch.priority_in = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: dequeue on empty, extreme priorities and data, a tie at the
    // top of the range and a run of equal priorities that must leave in
    // arrival order, then empty the queue and dequeue once more.
    dequeue();
    enqueue(32'h0000_0000, 32'sh7FFF_FFFF);
    enqueue(32'hFFFF_FFFF, 32'sh8000_0000);
    enqueue(32'hA5A5_A5A5, 32'sd0);
    enqueue(32'h5A5A_5A5A, -32'sd1);
    enqueue(32'h1234_5678, 32'sh7FFF_FFFF);
    enqueue(32'h0000_0001, 32'sd7);
    enqueue(32'h0000_0002, 32'sd7);
    enqueue(32'h0000_0003, 32'sd7);
    repeat (9) dequeue();
    enqueue(32'hDEAD_BEEF, 32'sh8000_0000);
    dequeue();
    drain_results();

    // Balanced traffic with gaps on both sides.
    src_idling  = 1'b1;
    sink_idling = 1'b1;
    random_burst(200, 55);
    drain_results();

    // Back-pressure: stall the sink for a long stretch while the sender
    // keeps pushing, so the block has to stall its input.
    src_idling   = 1'b0;
    sink_idling  = 1'b0;
    hold_off_req = 1'b1;
    random_burst(150, 75);
    drain_results();

    // Fill to capacity, knock on the full queue, then drain past empty.
    sink_idling = 1'b1;
    while (queued < DEPTH) enqueue(pick_data(), pick_priority());
    repeat (4) enqueue(pick_data(), pick_priority());
    src_idling = 1'b1;
    while (queued > 0) begin
      if ($urandom_range(0, 9) == 0) enqueue(pick_data(), pick_priority());
      else dequeue();
    end
    repeat (3) dequeue();
    drain_results();

    // Back-to-back stretch with no idling on either side.
    src_idling  = 1'b0;
    sink_idling = 1'b0;
    random_burst(60, 50);

    // Let the last results arrive, give stragglers a few cycles, then judge.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/pqms_pkg.sv
src/pqms_if.sv
src/pqms_cell.sv
src/priority_queue_max_select.sv
bench/pqms_checker.sv
bench/testbench.sv
